>>> hw/rtl/ppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PowerPC subset package
// Shared types and constants for the PowerPC subset core.
// ----------------------------------------------------------------------------
package ppc_pkg;
   localparam int MEM_BYTES = 65536;
   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int NUM_REGS = 32;

   localparam logic [5:0] OP_X     = 6'd31;
   localparam logic [5:0] OP_CMPI  = 6'd11;
   localparam logic [5:0] OP_ADDI  = 6'd14;
   localparam logic [5:0] OP_PRINT = 6'd1;
   localparam logic [5:0] OP_BC    = 6'd16;
   localparam logic [5:0] OP_XL    = 6'd19;
   localparam logic [5:0] OP_B     = 6'd18;
   localparam logic [5:0] OP_LWZ   = 6'd32;
   localparam logic [5:0] OP_STW   = 6'd36;
   localparam logic [5:0] OP_STWU  = 6'd37;
   localparam logic [5:0] OP_LMW   = 6'd46;
   localparam logic [5:0] OP_STMW  = 6'd47;

   localparam logic [8:0] XO9_ADD  = 9'd266;
   localparam logic [8:0] XO9_SUBF = 9'd40;
   localparam logic [9:0] XO_MFLR  = 10'd339;
   localparam logic [9:0] XO_MTLR  = 10'd467;
   localparam logic [9:0] XO_MR    = 10'd444;
   localparam logic [9:0] XO_CMP   = 10'd0;
   localparam logic [9:0] XO_SLW   = 10'd24;
   localparam logic [9:0] XO_BLR   = 10'd16;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        halted;
      logic        print_valid;
      logic [7:0]  print_char;
      logic signed [31:0] print_value;
      logic signed [31:0] final_value;
   } rsp_type;
endpackage

>>> hw/rtl/ppc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PowerPC subset channels
// Valid/ready channel interfaces for instructions and results.
// ----------------------------------------------------------------------------
interface ppc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;
   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface ppc_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        next_pc;
   logic               halted;
   logic               print_valid;
   logic [7:0]         print_char;
   logic signed [31:0] print_value;
   logic signed [31:0] final_value;
   modport source (output valid, output next_pc, output halted, output print_valid,
                   output print_char, output print_value, output final_value,
                   input ready);
   modport sink (input valid, input next_pc, input halted, input print_valid,
                 input print_char, input print_value, input final_value,
                 output ready);
endinterface

>>> hw/rtl/powerpc_subset_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PowerPC subset core
// Executes one instruction per item under a sequencer around one ALU.
// ----------------------------------------------------------------------------
// Sequence: register ops pass through read, execute and response; stw/stwu write
// one byte per cycle, then take an address step, and lwz reads each byte through
// the registered read port, then takes an address step;
// lmw/stmw repeat that for each register from rT to r31.
// Throughput: one item at a time; the next is taken once the result leaves.
// Reset: after reset a clearing pass zeroes every byte of the data
// memory, during which no item is accepted.
module powerpc_subset_core (
   input logic clock,
   input logic reset,
   ppc_req_if.sink   req,
   ppc_rsp_if.source rsp
);
   import ppc_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_READ  = 8'b00000100,
      S_EXEC  = 8'b00001000,
      S_MEM   = 8'b00010000,
      S_MWAIT = 8'b00100000,
      S_NEXT  = 8'b01000000,
      S_RSP   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] regs_ff [NUM_REGS];
   logic [31:0] link_ff;
   logic [2:0]  cr_ff [8];
   logic [15:0] pc_ff;
   logic [31:0] ir_ff;
   logic [31:0] a_ff, b_ff, ea_ff, word_ff;
   logic [4:0]  r_ff;
   logic [1:0]  byte_ff;
   logic [MEM_AW:0] clr_ff;
   rsp_type     out_ff;

   logic [5:0] op;
   logic [4:0] f1, f2, f3;
   logic [9:0] xo;
   logic [8:0] xo9;
   logic [31:0] imm;
   assign op  = ir_ff[31:26];
   assign f1  = ir_ff[25:21];
   assign f2  = ir_ff[20:16];
   assign f3  = ir_ff[15:11];
   assign xo  = ir_ff[10:1];
   assign xo9 = ir_ff[9:1];
   assign imm = {{16{ir_ff[15]}}, ir_ff[15:0]};

   logic is_load, is_store, is_multi;
   assign is_load  = (op == OP_LWZ) || (op == OP_LMW);
   assign is_store = (op == OP_STW) || (op == OP_STWU) || (op == OP_STMW);
   assign is_multi = (op == OP_LMW) || (op == OP_STMW);

   logic [MEM_AW-1:0] m_addr;
   logic        m_we;
   logic [7:0]  m_wd, m_rd;
   logic [31:0] byte_ea;
   assign byte_ea = ea_ff + {30'd0, byte_ff};
   always_comb begin
      m_wd = 8'd0;
      unique case (byte_ff)
         2'd0: m_wd = word_ff[31:24];
         2'd1: m_wd = word_ff[23:16];
         2'd2: m_wd = word_ff[15:8];
         2'd3: m_wd = word_ff[7:0];
      endcase
   end
   assign m_addr = (state_ff == S_CLEAR) ? clr_ff[MEM_AW-1:0] : byte_ea[MEM_AW-1:0];
   assign m_we = (state_ff == S_CLEAR) || ((state_ff == S_MEM) && is_store);

   ppc_dmem u_dmem (
      .clock   (clock),
      .addr    (m_addr),
      .wr_en   (m_we),
      .wr_data ((state_ff == S_CLEAR) ? 8'd0 : m_wd),
      .rd_data (m_rd)
   );

   // Shared ALU.
   logic [31:0] alu_sum, alu_diff, alu_shl;
   logic        alu_lt, alu_eq;
   assign alu_sum  = a_ff + b_ff;
   assign alu_diff = b_ff - a_ff;
   assign alu_shl  = b_ff[5] ? 32'd0 : (a_ff << b_ff[4:0]);
   assign alu_lt   = $signed(a_ff) < $signed(b_ff);
   assign alu_eq   = a_ff == b_ff;

   logic [2:0] cf;
   assign cf = cr_ff[f2[4:2]];

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RSP);
   assign rsp.next_pc = out_ff.next_pc;
   assign rsp.halted = out_ff.halted;
   assign rsp.print_valid = out_ff.print_valid;
   assign rsp.print_char = out_ff.print_char;
   assign rsp.print_value = out_ff.print_value;
   assign rsp.final_value = out_ff.final_value;

   logic [31:0] base;
   assign base = (f2 == 5'd0) ? 32'd0 : regs_ff[f2];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == MEM_AW'(0) + (MEM_AW+1)'(MEM_BYTES - 1)) state_in = S_IDLE;
         S_IDLE:  if (req.valid) state_in = S_READ;
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = (is_load || is_store) ? S_MEM : S_RSP;
         S_MEM:   state_in = is_load ? S_MWAIT : ((byte_ff == 2'd3) ? S_NEXT : S_MEM);
         S_MWAIT: state_in = (byte_ff == 2'd3) ? S_NEXT : S_MEM;
         S_NEXT:  state_in = (is_multi && r_ff != 5'd31) ? S_MEM : S_RSP;
         S_RSP:   if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= 16'd0;
         link_ff <= 32'hFFFF_FFFF;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= (i == 1) ? 32'd2000 : ((i == 3) ? 32'd5000 : 32'd0);
         end
         for (int i = 0; i < 8; i++) cr_ff[i] <= 3'd0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + 1'b1;
            S_IDLE: if (req.valid) ir_ff <= req.instruction;
            S_READ: begin
               byte_ff <= 2'd0;
               r_ff <= f1;
               out_ff <= '{next_pc: pc_ff + 16'd4, default: '0};
               priority if (op == OP_X) begin
                  a_ff <= (xo9 == XO9_ADD || xo9 == XO9_SUBF || xo == XO_CMP)
                          ? regs_ff[f2] : regs_ff[f1];
                  b_ff <= regs_ff[f3];
               end else if (op == OP_STWU) begin
                  a_ff <= regs_ff[f2];
                  b_ff <= imm;
               end else begin
                  a_ff <= (op == OP_CMPI) ? regs_ff[f2] : base;
                  b_ff <= imm;
               end
            end
            S_EXEC: begin
               ea_ff <= alu_sum;
               word_ff <= regs_ff[f1];
               priority case (op)
                  OP_X: begin
                     priority if (xo9 == XO9_ADD) regs_ff[f1] <= alu_sum;
                     else if (xo9 == XO9_SUBF) regs_ff[f1] <= alu_diff;
                     else if (xo == XO_MFLR) regs_ff[f1] <= link_ff;
                     else if (xo == XO_MTLR) link_ff <= regs_ff[f1];
                     else if (xo == XO_MR) regs_ff[f2] <= regs_ff[f1];
                     else if (xo == XO_CMP)
                        cr_ff[f1[4:2]] <= alu_lt ? 3'd4 : (alu_eq ? 3'd1 : 3'd2);
                     else if (xo == XO_SLW) regs_ff[f2] <= alu_shl;
                     else begin
                        out_ff.halted <= 1'b1;
                        out_ff.next_pc <= pc_ff;
                        out_ff.final_value <= regs_ff[3];
                     end
                  end
                  OP_CMPI: cr_ff[f1[4:2]] <= alu_lt ? 3'd4 : (alu_eq ? 3'd1 : 3'd2);
                  OP_ADDI: regs_ff[f1] <= alu_sum;
                  OP_PRINT: begin
                     out_ff.print_valid <= 1'b1;
                     out_ff.print_char <= regs_ff[f1][7:0];
                     out_ff.print_value <= regs_ff[2];
                  end
                  OP_BC: begin
                     if (ir_ff[1:0] != 2'd0 || !(f1 == 5'd4 || f1 == 5'd2 || f1 == 5'd1)) begin
                        out_ff.halted <= 1'b1;
                        out_ff.next_pc <= pc_ff;
                        out_ff.final_value <= regs_ff[3];
                     end else if ((f1 == 5'd4 && !cf[0]) || (f1 == 5'd2 && cf[1])
                                  || (f1 == 5'd1 && cf[2]))
                        out_ff.next_pc <= pc_ff + {ir_ff[15:2], 2'b00};
                  end
                  OP_XL: begin
                     if (xo != XO_BLR) begin
                        out_ff.halted <= 1'b1;
                        out_ff.next_pc <= pc_ff;
                        out_ff.final_value <= regs_ff[3];
                     end else if (link_ff != 32'hFFFF_FFFF)
                        out_ff.next_pc <= link_ff[15:0];
                  end
                  OP_B: begin
                     if (ir_ff[0]) link_ff <= {16'd0, pc_ff + 16'd4};
                     out_ff.next_pc <= pc_ff + {ir_ff[15:2], 2'b00};
                  end
                  OP_STWU: regs_ff[f2] <= alu_sum;
                  OP_LWZ, OP_STW, OP_LMW, OP_STMW: ;
                  default: begin
                     out_ff.halted <= 1'b1;
                     out_ff.next_pc <= pc_ff;
                     out_ff.final_value <= regs_ff[3];
                  end
               endcase
            end
            S_MEM: begin
               if (is_store) byte_ff <= byte_ff + 2'd1;
            end
            S_MWAIT: begin
               word_ff <= {word_ff[23:0], m_rd};
               byte_ff <= byte_ff + 2'd1;
               if (byte_ff == 2'd3) regs_ff[r_ff] <= {word_ff[23:0], m_rd};
            end
            S_NEXT: begin
               ea_ff <= ea_ff + 32'd4;
               r_ff <= r_ff + 5'd1;
               word_ff <= regs_ff[r_ff + 5'd1];
               byte_ff <= 2'd0;
            end
            S_RSP: if (rsp.ready) pc_ff <= out_ff.next_pc;
            default: ;
         endcase
      end
   end
endmodule

>>> hw/rtl/ppc_dmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PowerPC subset data memory
// Byte-wide data memory with one shared address for a registered read and a write.
// ----------------------------------------------------------------------------
module ppc_dmem (
   input  logic                      clock,
   input  logic [ppc_pkg::MEM_AW-1:0] addr,
   input  logic                      wr_en,
   input  logic [7:0]                wr_data,
   output logic [7:0]                rd_data
);
   import ppc_pkg::*;
   logic [7:0] mem [MEM_BYTES];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
